@@ rtl/tevq_pkg.sv @@
// shared types and codes for the timed event queue
package tevq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TIME_W = 47;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [3:0]        ev_type;
    logic [7:0]        ev_owner;
  } entry_t;

  // operation codes
  localparam logic [2:0] K_INSERT  = 3'd0;
  localparam logic [2:0] K_PEEK    = 3'd1;
  localparam logic [2:0] K_POP     = 3'd2;
  localparam logic [2:0] K_REM_ONE = 3'd3;
  localparam logic [2:0] K_REM_ALL = 3'd4;
  localparam logic [2:0] K_ALM_SCH = 3'd5;
  localparam logic [2:0] K_ALM_TRF = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // event type codes
  localparam logic [3:0] T_ALARM_TRAFFIC      = 4'd5;
  localparam logic [3:0] T_FLOW_FINISH        = 4'd6;
  localparam logic [3:0] T_RESCHEDULE         = 4'd9;
  localparam logic [3:0] T_ORDER_CIRCUIT      = 4'd10;
  localparam logic [3:0] T_APPLY_CIRCUIT      = 4'd11;
  localparam logic [3:0] T_APPLY_NEW_SCHEDULE = 4'd12;
  localparam logic [3:0] T_SCHEDULE_END       = 4'd13;
  localparam logic [3:0] T_ALARM_SCHEDULER    = 4'd15;

endpackage

@@ rtl/timed_event_queue.sv @@
// timed event queue: time-ordered event store with a copying pass over two memory banks
// sequence: trivial requests go from the accepting edge straight to the finish state,
//   which raises out_valid once no stalled result is held; peek, pop, removals and
//   inserts first run one pass over the held entries, then finish
// transactions: one at a time, paced by the single read port walking the active bank
//   while the other is rewritten
// reset: fill count, bank select and output valid clear at once, no memory clearing pass
module timed_event_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_kind,
  input  logic signed [47:0]        in_event_time,
  input  logic [3:0]                in_event_type,
  input  logic [7:0]                in_owner,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic                      out_event_valid,
  output logic [tevq_pkg::TIME_W-1:0] out_time,
  output logic [3:0]                out_type,
  output logic [7:0]                out_owner,
  output logic [tevq_pkg::CNT_W-1:0] out_occupancy
);
  import tevq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PASS = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // two banks in one memory, bank select is the top address bit
  entry_t mem [2*DEPTH];
  entry_t rdata_r;

  logic [1:0]        state_r, state_nxt;
  logic              bank_r, bank_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  ci_r, ci_nxt;
  logic [CNT_W-1:0]  w_r, w_nxt;
  logic [2:0]        kind_r, kind_nxt;
  entry_t            new_r, new_nxt;
  logic [3:0]        tp_r, tp_nxt;
  logic              do_ins_r, do_ins_nxt;
  logic              ins_done_r, ins_done_nxt;
  logic              drop_done_r, drop_done_nxt;
  logic              head_match_r, head_match_nxt;
  logic              commit_r, commit_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              evv_r, evv_nxt;
  entry_t            head_r, head_nxt;

  logic              ov_r, ov_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic              oev_r, oev_nxt;
  entry_t            oent_r, oent_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic              in_acc, neg, empty, ins_now, drop, singular;
  logic [CNT_W-1:0]  w_fin;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign neg      = in_event_time[47];
  assign empty    = (fill_r == '0);

  always_comb begin
    singular = 1'b0;
    case (in_event_type)
      T_FLOW_FINISH, T_RESCHEDULE, T_ORDER_CIRCUIT, T_APPLY_CIRCUIT,
      T_APPLY_NEW_SCHEDULE, T_SCHEDULE_END: singular = 1'b1;
      default: singular = 1'b0;
    endcase
  end

  // memory: one write into the idle bank, one registered read from the active bank
  always_ff @(posedge clk) begin
    if (we) begin
      mem[{~bank_r, waddr}] <= wdata;
    end
    rdata_r <= mem[{bank_r, ci_nxt[IDX_W-1:0]}];
  end

  // drop decision for the entry in the read register
  always_comb begin
    drop = 1'b0;
    case (kind_r)
      K_POP:     drop = (ci_r == '0);
      K_REM_ONE: drop = (ci_r != '0) && !head_match_r && !drop_done_r &&
                        (rdata_r.ev_type == tp_r);
      K_REM_ALL: drop = (ci_r != '0) && (rdata_r.ev_type == T_APPLY_CIRCUIT);
      K_ALM_SCH: drop = (ci_r != '0) && !drop_done_r &&
                        (rdata_r.ev_type == T_ALARM_SCHEDULER) &&
                        (rdata_r.ev_owner == new_r.ev_owner);
      K_ALM_TRF: drop = (ci_r != '0) && !drop_done_r &&
                        (rdata_r.ev_type == T_ALARM_TRAFFIC);
      default:   drop = 1'b0;
    endcase
  end

  assign ins_now = do_ins_r && !ins_done_r && (rdata_r.ev_time > new_r.ev_time);
  assign w_fin   = w_r + CNT_W'(do_ins_r && !ins_done_r);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    bank_nxt       = bank_r;
    fill_nxt       = fill_r;
    ci_nxt         = '0;
    w_nxt          = w_r;
    kind_nxt       = kind_r;
    new_nxt        = new_r;
    tp_nxt         = tp_r;
    do_ins_nxt     = do_ins_r;
    ins_done_nxt   = ins_done_r;
    drop_done_nxt  = drop_done_r;
    head_match_nxt = head_match_r;
    commit_nxt     = commit_r;
    st_nxt         = st_r;
    evv_nxt        = evv_r;
    head_nxt       = head_r;
    ov_nxt         = ov_r && out_stall;
    ost_nxt        = ost_r;
    oev_nxt        = oev_r;
    oent_nxt       = oent_r;
    occ_nxt        = occ_r;
    we             = 1'b0;
    waddr          = w_r[IDX_W-1:0];
    wdata          = rdata_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt         = in_kind;
          tp_nxt           = in_event_type;
          new_nxt.ev_time  = in_event_time[TIME_W-1:0];
          new_nxt.ev_type  = in_event_type;
          new_nxt.ev_owner = in_owner;
          do_ins_nxt       = 1'b0;
          ins_done_nxt     = 1'b0;
          drop_done_nxt    = 1'b0;
          head_match_nxt   = 1'b0;
          commit_nxt       = 1'b1;
          st_nxt           = ST_OK;
          evv_nxt          = 1'b0;
          w_nxt            = '0;
          state_nxt        = S_PASS;
          case (in_kind)
            K_INSERT: begin
              if (neg) begin
                st_nxt = ST_ILLEGAL; state_nxt = S_FIN;
              end else if (fill_r == CNT_W'(DEPTH)) begin
                st_nxt = ST_FULL; state_nxt = S_FIN;
              end else begin
                do_ins_nxt = 1'b1;
              end
            end
            K_PEEK, K_POP: begin
              if (empty) begin
                st_nxt = ST_EMPTY; state_nxt = S_FIN;
              end else begin
                evv_nxt    = 1'b1;
                commit_nxt = (in_kind == K_POP);
              end
            end
            K_REM_ONE: begin
              if (empty) begin
                state_nxt = S_FIN;
              end else if (!singular) begin
                st_nxt = ST_ILLEGAL; state_nxt = S_FIN;
              end
            end
            K_REM_ALL: begin
              if (empty) begin
                state_nxt = S_FIN;
              end else if (in_event_type != T_APPLY_CIRCUIT) begin
                st_nxt = ST_ILLEGAL; state_nxt = S_FIN;
              end
            end
            K_ALM_SCH, K_ALM_TRF: begin
              new_nxt.ev_type  = (in_kind == K_ALM_SCH) ? T_ALARM_SCHEDULER
                                                        : T_ALARM_TRAFFIC;
              new_nxt.ev_owner = (in_kind == K_ALM_SCH) ? in_owner : 8'd0;
              do_ins_nxt       = !neg;
              if (neg) st_nxt = ST_ILLEGAL;
              if (empty && neg) state_nxt = S_FIN;
            end
            default: begin
              st_nxt = ST_ILLEGAL; state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_PASS: begin
        if (ci_r < fill_r) begin
          if (ins_now) begin
            // new entry goes ahead of this one, re-read the same slot
            we           = (w_r < CNT_W'(DEPTH));
            wdata        = new_r;
            w_nxt        = w_r + 1'b1;
            ins_done_nxt = 1'b1;
            ci_nxt       = ci_r;
          end else begin
            if (ci_r == '0) begin
              head_nxt       = rdata_r;
              head_match_nxt = (rdata_r.ev_type == tp_r);
            end
            if (drop) begin
              drop_done_nxt = 1'b1;
            end else begin
              we    = (w_r < CNT_W'(DEPTH));
              w_nxt = w_r + 1'b1;
            end
            ci_nxt = ci_r + 1'b1;
          end
        end else begin
          // tail insert and commit of the rewritten bank
          if (do_ins_r && !ins_done_r) begin
            we    = (w_r < CNT_W'(DEPTH));
            wdata = new_r;
          end
          if (w_fin > CNT_W'(DEPTH)) begin
            st_nxt = ST_FULL;
          end else if (commit_r) begin
            bank_nxt = ~bank_r;
            fill_nxt = w_fin;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ost_nxt   = st_r;
          oev_nxt   = evv_r;
          oent_nxt  = evv_r ? head_r : '0;
          occ_nxt   = fill_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bank_r  <= 1'b0;
      fill_r  <= '0;
      ci_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bank_r  <= bank_nxt;
      fill_r  <= fill_nxt;
      ci_r    <= ci_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload and per-transaction working registers
  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    kind_r       <= kind_nxt;
    new_r        <= new_nxt;
    tp_r         <= tp_nxt;
    do_ins_r     <= do_ins_nxt;
    ins_done_r   <= ins_done_nxt;
    drop_done_r  <= drop_done_nxt;
    head_match_r <= head_match_nxt;
    commit_r     <= commit_nxt;
    st_r         <= st_nxt;
    evv_r        <= evv_nxt;
    head_r       <= head_nxt;
    ost_r        <= ost_nxt;
    oev_r        <= oev_nxt;
    oent_r       <= oent_nxt;
    occ_r        <= occ_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_event_valid = oev_r;
  assign out_time        = oent_r.ev_time;
  assign out_type        = oent_r.ev_type;
  assign out_owner       = oent_r.ev_owner;
  assign out_occupancy   = occ_r;

endmodule

@@ rtl/tevq_checker.sv @@
// port-level checks for the timed event queue
module tevq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_status,
  input logic                        out_event_valid,
  input logic [tevq_pkg::TIME_W-1:0] out_time,
  input logic [3:0]                  out_type,
  input logic [7:0]                  out_owner,
  input logic [tevq_pkg::CNT_W-1:0]  out_occupancy
);
  import tevq_pkg::*;

  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_time) && $stable(out_occupancy))
    else $error("stalled result changed");

  // a returned event comes only with ok status
  a_ev_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_valid |-> out_status == ST_OK)
    else $error("event returned with error status");

  // no event means zeroed event fields
  a_ev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_valid |-> out_time == '0 && out_type == '0 && out_owner == '0)
    else $error("event fields not cleared");

  // occupancy never exceeds the depth
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  // empty status only on an empty queue
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_occupancy == '0 && !out_event_valid)
    else $error("empty status with entries held");

endmodule

bind timed_event_queue tevq_checker u_tevq_checker (.*);
